[src/sbl_pkg.sv]
// shared types, constants and character-class functions for the script byte lexer
package sbl_pkg;

    localparam int LINE_BITS     = 20;
    localparam int TYPE_W        = 5;
    localparam int VAL_W         = 64;
    localparam int MAX_RESULTS   = 4;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W     = $clog2(MAX_RESULTS);

    // result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // token types; the single-character symbols follow TT_IDENT
    localparam logic [TYPE_W-1:0] TT_EOF    = 5'd0;
    localparam logic [TYPE_W-1:0] TT_FLAG   = 5'd1;
    localparam logic [TYPE_W-1:0] TT_VAR    = 5'd2;
    localparam logic [TYPE_W-1:0] TT_INT    = 5'd3;
    localparam logic [TYPE_W-1:0] TT_REAL   = 5'd4;
    localparam logic [TYPE_W-1:0] TT_STRING = 5'd5;
    localparam logic [TYPE_W-1:0] TT_IDENT  = 5'd6;
    localparam logic [TYPE_W-1:0] TT_OPEN_PAR  = 5'd7;
    localparam logic [TYPE_W-1:0] TT_CLOSE_PAR = 5'd8;
    localparam logic [TYPE_W-1:0] TT_OPEN_BRC  = 5'd9;
    localparam logic [TYPE_W-1:0] TT_CLOSE_BRC = 5'd10;
    localparam logic [TYPE_W-1:0] TT_SEP    = 5'd11;
    localparam logic [TYPE_W-1:0] TT_ASSIGN = 5'd12;
    localparam logic [TYPE_W-1:0] TT_ADD    = 5'd13;
    localparam logic [TYPE_W-1:0] TT_SUB    = 5'd14;
    localparam logic [TYPE_W-1:0] TT_STAR   = 5'd15;
    localparam logic [TYPE_W-1:0] TT_SLASH  = 5'd16;
    localparam logic [TYPE_W-1:0] TT_SEMI   = 5'd17;

    // characters the lexer decides on
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UPPERX = 8'h58;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOWERX = 8'h78;

    localparam logic [4:0] HEX_NONE = 5'd16;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_COMMENT = 7'b0000010,
        MODE_FLAG    = 7'b0000100,
        MODE_VAR     = 7'b0001000,
        MODE_NUMBER  = 7'b0010000,
        MODE_STRING  = 7'b0100000,
        MODE_IDENT   = 7'b1000000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_source;
    } sbl_in_t;

    typedef struct packed {
        logic                 result_kind;
        logic [TYPE_W-1:0]    token_type;
        logic [7:0]           text_byte;
        logic [LINE_BITS-1:0] line_number;
        logic [VAL_W-1:0]     int_value;
        logic                 last_of_run;
    } sbl_out_t;

    typedef struct packed {
        logic             hex;
        logic             flt;
        logic             stop;
        logic [VAL_W-1:0] accum;
    } num_t;

    typedef struct packed {
        lex_mode_t            mode;
        logic [7:0]           pend_char;
        logic                 pend_valid;
        logic [LINE_BITS-1:0] line_cnt;
        logic [LINE_BITS-1:0] tok_line;
        num_t                 num;
    } lex_state_t;

    typedef struct packed {
        sbl_out_t [MAX_RESULTS-1:0] items;
        logic [CNT_W-1:0]           count;
    } sbl_bundle_t;

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    localparam lex_state_t LEX_RESET = '{
        mode:       MODE_IDLE,
        pend_char:  8'h00,
        pend_valid: 1'b0,
        line_cnt:   LINE_ONE,
        tok_line:   LINE_ONE,
        num:        '0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] d;
        if (is_digit(c)) begin
            d = 5'(c - "0");
        end else if ((c >= "a") && (c <= "f")) begin
            d = 5'(c - "a" + 8'd10);
        end else if ((c >= "A") && (c <= "F")) begin
            d = 5'(c - "A" + 8'd10);
        end else begin
            d = HEX_NONE;
        end
        return d;
    endfunction

    // zero means no symbol
    function automatic logic [TYPE_W-1:0] symbol_type(input logic [7:0] c);
        logic [TYPE_W-1:0] t;
        case (c)
            "(":     t = TT_OPEN_PAR;
            ")":     t = TT_CLOSE_PAR;
            "{":     t = TT_OPEN_BRC;
            "}":     t = TT_CLOSE_BRC;
            ",":     t = TT_SEP;
            "=":     t = TT_ASSIGN;
            "+":     t = TT_ADD;
            "-":     t = TT_SUB;
            "*":     t = TT_STAR;
            "/":     t = TT_SLASH;
            ";":     t = TT_SEMI;
            default: t = TT_EOF;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] escape_val(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LOW_N: r = CH_NL;
            CH_LOW_T: r = CH_TAB;
            CH_LOW_R: r = CH_CR;
            default:  r = c;
        endcase
        return r;
    endfunction

    // one byte into a number: dots make it float, digits accumulate with saturation
    function automatic num_t num_step(input num_t n, input logic [7:0] c);
        num_t       r;
        logic [4:0] d;
        logic [VAL_W+3:0] t;
        r = n;
        d = hex_val(c);
        t = '0;
        if (c == CH_DOT) begin
            r.flt  = 1'b1;
            r.stop = 1'b1;
        end else if (!n.stop) begin
            if (n.hex) begin
                if (d == HEX_NONE) begin
                    r.stop = 1'b1;
                end else if (n.accum[VAL_W-1 -: 4] != 4'h0) begin
                    r.accum = {VAL_W{1'b1}};
                end else begin
                    r.accum = {n.accum[VAL_W-5:0], d[3:0]};
                end
            end else begin
                if (d >= 5'd10) begin
                    r.stop = 1'b1;
                end else begin
                    t = ({4'h0, n.accum} << 3) + ({4'h0, n.accum} << 1)
                        + (VAL_W+4)'(d);
                    r.accum = (t[VAL_W+3:VAL_W] != 4'h0) ? {VAL_W{1'b1}}
                                                         : t[VAL_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic sbl_out_t text_rec(input logic [7:0] c,
                                          input logic [LINE_BITS-1:0] line);
        sbl_out_t r;
        r = '0;
        r.result_kind = KIND_TEXT;
        r.text_byte   = c;
        r.line_number = line;
        return r;
    endfunction

    function automatic sbl_out_t end_rec(input logic [TYPE_W-1:0] t,
                                         input logic [LINE_BITS-1:0] line,
                                         input logic [VAL_W-1:0] v);
        sbl_out_t r;
        r = '0;
        r.result_kind = KIND_END;
        r.token_type  = t;
        r.line_number = line;
        r.int_value   = v;
        return r;
    endfunction

    function automatic logic tok_open(input lex_mode_t m);
        return (m == MODE_FLAG) || (m == MODE_VAR) || (m == MODE_NUMBER)
            || (m == MODE_STRING) || (m == MODE_IDENT);
    endfunction

    // end record for the open token
    function automatic sbl_out_t close_rec(input lex_state_t s);
        logic [TYPE_W-1:0] t;
        logic [VAL_W-1:0]  v;
        v = '0;
        case (s.mode)
            MODE_FLAG:   t = TT_FLAG;
            MODE_VAR:    t = TT_VAR;
            MODE_STRING: t = TT_STRING;
            MODE_IDENT:  t = TT_IDENT;
            MODE_NUMBER: begin
                if (s.num.flt) begin
                    t = TT_REAL;
                end else begin
                    t = TT_INT;
                    v = s.num.accum;
                end
            end
            default:     t = TT_EOF;
        endcase
        return end_rec(t, s.tok_line, v);
    endfunction

    function automatic sbl_bundle_t push(input sbl_bundle_t b, input sbl_out_t r);
        sbl_bundle_t o;
        o = b;
        if (b.count < CNT_W'(MAX_RESULTS)) begin
            o.items[b.count[RES_IDX_W-1:0]] = r;
            o.count = b.count + CNT_W'(1);
        end
        return o;
    endfunction

endpackage

[src/sbl_step.sv]
// next-state and result logic for one source beat of the lexer
module sbl_step (
    input  sbl_pkg::lex_state_t  cur_st,
    input  sbl_pkg::sbl_in_t     beat,
    output sbl_pkg::lex_state_t  nxt_st,
    output sbl_pkg::sbl_bundle_t bundle
);
    import sbl_pkg::*;

    logic [7:0] c;
    logic [7:0] la;
    logic       lav;
    logic       consumed;
    logic       go_idle;
    num_t       num_in;
    num_t       num_out;
    lex_state_t nx;
    sbl_bundle_t bd;

    assign c   = cur_st.pend_char;
    assign la  = beat.src_byte;
    assign lav = !beat.end_of_source;

    // one shared accumulator update: continuing number or a fresh one
    assign num_in  = (cur_st.mode == MODE_NUMBER) ? cur_st.num : '0;
    assign num_out = num_step(num_in, c);

    always_comb begin
        nx       = cur_st;
        bd       = '0;
        consumed = 1'b0;
        go_idle  = 1'b0;

        if (cur_st.pend_valid) begin
            // continue the open token, or close it and, unless it ends a string, rescan the byte
            unique case (cur_st.mode)
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        go_idle = 1'b1;
                    end
                end
                MODE_FLAG, MODE_VAR, MODE_IDENT: begin
                    if (is_name(c) || ((cur_st.mode == MODE_FLAG)
                                       && ((c == CH_MINUS) || (c == CH_EQ)))) begin
                        bd = push(bd, text_rec(c, cur_st.tok_line));
                    end else begin
                        bd      = push(bd, close_rec(cur_st));
                        go_idle = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if ((hex_val(c) != HEX_NONE) || (c == CH_DOT)) begin
                        bd     = push(bd, text_rec(c, cur_st.tok_line));
                        nx.num = num_out;
                    end else begin
                        bd      = push(bd, close_rec(cur_st));
                        go_idle = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        bd      = push(bd, close_rec(cur_st));
                        nx.mode = MODE_IDLE;
                    end else if ((c == CH_BSLASH) && lav) begin
                        bd       = push(bd, text_rec(escape_val(la), cur_st.tok_line));
                        consumed = 1'b1;
                    end else begin
                        bd = push(bd, text_rec(c, cur_st.tok_line));
                    end
                end
                MODE_IDLE: go_idle = 1'b1;
                default:   go_idle = 1'b1;
            endcase

            if (go_idle) begin
                nx.mode = MODE_IDLE;
                if (is_space(c)) begin
                    if ((c == CH_NL) && (cur_st.line_cnt != LINE_MAX)) begin
                        nx.line_cnt = cur_st.line_cnt + LINE_ONE;
                    end
                end else if ((c == CH_SLASH) && lav && (la == CH_SLASH)) begin
                    nx.mode = MODE_COMMENT;
                end else if ((c == CH_MINUS) && lav && (la == CH_MINUS)) begin
                    nx.mode     = MODE_FLAG;
                    nx.tok_line = cur_st.line_cnt;
                    bd          = push(bd, text_rec(c, cur_st.line_cnt));
                    bd          = push(bd, text_rec(la, cur_st.line_cnt));
                    consumed    = 1'b1;
                end else if (c == CH_DOLLAR) begin
                    nx.mode     = MODE_VAR;
                    nx.tok_line = cur_st.line_cnt;
                    bd          = push(bd, text_rec(c, cur_st.line_cnt));
                end else if (is_digit(c) || ((c == CH_DOT) && lav && is_digit(la))) begin
                    nx.mode     = MODE_NUMBER;
                    nx.tok_line = cur_st.line_cnt;
                    bd          = push(bd, text_rec(c, cur_st.line_cnt));
                    if ((c == CH_ZERO) && lav && ((la == CH_LOWERX) || (la == CH_UPPERX))) begin
                        nx.num     = '0;
                        nx.num.hex = 1'b1;
                        bd         = push(bd, text_rec(la, cur_st.line_cnt));
                        consumed   = 1'b1;
                    end else begin
                        nx.num = num_out;
                    end
                end else if (c == CH_QUOTE) begin
                    nx.mode     = MODE_STRING;
                    nx.tok_line = cur_st.line_cnt;
                end else if (is_alpha(c) || (c == CH_UNDER)) begin
                    nx.mode     = MODE_IDENT;
                    nx.tok_line = cur_st.line_cnt;
                    bd          = push(bd, text_rec(c, cur_st.line_cnt));
                end else if (symbol_type(c) != TT_EOF) begin
                    nx.tok_line = cur_st.line_cnt;
                    bd          = push(bd, text_rec(c, cur_st.line_cnt));
                    bd          = push(bd, end_rec(symbol_type(c), cur_st.line_cnt, '0));
                end
            end
        end

        if (beat.end_of_source) begin
            // close what is open, report eof, start over
            if (tok_open(nx.mode)) begin
                bd = push(bd, close_rec(nx));
            end
            bd = push(bd, end_rec(TT_EOF, nx.line_cnt, '0));
            nx = LEX_RESET;
        end else if (cur_st.pend_valid) begin
            if (consumed) begin
                nx.pend_valid = 1'b0;
            end else begin
                nx.pend_char = la;
            end
        end else begin
            nx.pend_char  = la;
            nx.pend_valid = 1'b1;
        end
    end

    assign nxt_st = nx;
    assign bundle = bd;

endmodule

[src/script_byte_lexer.sv]
// top level of the script byte lexer: lexer state, result buffer and handshakes
//
// Streaming tokenizer. Source bytes come in on the s_ channel, one per beat;
// a beat with end_of_source set ends the source. The lexer holds one byte
// back so every decision can see the next byte, so the results for a byte
// appear when the byte after it (or end of source) is accepted. Each beat
// yields zero to four result beats on the m_ channel: token text bytes
// (strings decoded, quotes dropped) and token end records carrying type,
// start line and saturated integer value, with last_of_run on the final
// result of the beat. End of source closes any open token, adds an eof
// record and returns the lexer to its reset state at line 1.
// Timing: all work for a beat is one pass of combinational logic into the
// result buffer, so results are visible the cycle after the beat is taken.
// The buffer drains one result per cycle while m_ready is high, which sets
// the rate: the input waits while more than the last result remains, so plain
// source streams at one byte per cycle while m_ready holds. A new beat is taken in
// the same cycle the last buffered result leaves.
module script_byte_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbl_pkg::sbl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sbl_pkg::sbl_out_t m_data
);
    import sbl_pkg::*;

    // lexer state
    lex_state_t st_reg;
    lex_state_t st_next;

    // result buffer: up to four records from the last beat
    sbl_out_t [MAX_RESULTS-1:0] items_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [RES_IDX_W-1:0]       pos_reg;

    sbl_bundle_t bundle;
    logic        s_fire;
    logic        m_fire;
    sbl_out_t    head;

    sbl_step u_step (
        .cur_st (st_reg),
        .beat   (s_data),
        .nxt_st (st_next),
        .bundle (bundle)
    );

    // results waiting in the buffer
    assign m_valid = (rem_reg != '0);
    assign m_fire  = m_valid && m_ready;

    // take a new beat when the buffer is empty or its last record leaves now
    assign s_ready = (rem_reg == '0) || ((rem_reg == CNT_W'(1)) && m_ready);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        head             = items_reg[pos_reg];
        head.last_of_run = (rem_reg == CNT_W'(1));
    end
    assign m_data = head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= LEX_RESET;
            rem_reg <= '0;
            pos_reg <= '0;
        end else begin
            if (s_fire) begin
                st_reg  <= st_next;
                rem_reg <= bundle.count;
                pos_reg <= '0;
            end else if (m_fire) begin
                rem_reg <= rem_reg - CNT_W'(1);
                pos_reg <= pos_reg + RES_IDX_W'(1);
            end
        end
    end

    // record payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            items_reg <= bundle.items;
        end
    end

    // buffer read pointer and remaining count never run past its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(pos_reg) + rem_reg) <= CNT_W'(MAX_RESULTS))
        else $error("result buffer overrun");

    // end of source always leaves at least the eof record in the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_source) |=> (rem_reg != '0))
        else $error("end of source without eof record");

    // after end of source the lexer restarts at line one with nothing held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_source) |=>
            ((st_reg.mode == MODE_IDLE) && !st_reg.pend_valid
             && (st_reg.line_cnt == LINE_ONE)))
        else $error("lexer not restarted after end of source");

    // the record that ends a source beat's results on eof is an end record
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_source) |=>
            (items_reg[rem_reg[RES_IDX_W-1:0] - RES_IDX_W'(1)].result_kind == KIND_END))
        else $error("eof beat did not end with an end record");

endmodule
